FILE: rtl/lap_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGB 3x3 Laplacian filter core.
// No dependencies; every other file of the core imports this package.
package lap_pkg;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int DIM_W  = 12;
    localparam int CFG_IDX_W = 1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Red sits in the lowest byte.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    // Position flags of one output pixel inside the frame.
    typedef struct packed {
        logic emit;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } lap_ctl_t;

endpackage

FILE: rtl/lap_ctrl.sv
`timescale 1ns / 1ps
// Configuration registers and raster position counters of the filter core.
// Depends on lap_pkg.
module lap_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int COL_BITS   = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lap_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          in_fire,
    input  logic                          req_type,
    output logic                          proc,
    output logic                          draining,
    output logic [COL_BITS-1:0]           col,
    output lap_pkg::lap_ctl_t             ctl
);
    import lap_pkg::*;

    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);

    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] ocol_reg, ocol_next;
    logic [ROW_BITS-1:0] orow_reg, orow_next;

    logic [W_BITS-1:0]   w_eff;
    logic [H_BITS-1:0]   h_eff;
    logic [ROW_BITS-1:0] h_row;
    logic                col_end;
    logic                ocol_end;
    logic                emit;
    logic                last;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = W_BITS'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = W_BITS'(MAX_WIDTH);
        else
            w_eff = W_BITS'(width_reg);

        if (height_reg == '0)
            h_eff = H_BITS'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = H_BITS'(MAX_HEIGHT);
        else
            h_eff = H_BITS'(height_reg);
    end

    assign h_row    = ROW_BITS'(h_eff);
    assign draining = row_reg >= h_row;
    assign proc     = in_fire && (draining || !req_type);
    assign col_end  = (W_BITS'(col_reg) + W_BITS'(1)) == w_eff;
    assign ocol_end = (W_BITS'(ocol_reg) + W_BITS'(1)) == w_eff;
    assign emit     = (row_reg >= ROW_BITS'(2)) || (row_reg == ROW_BITS'(1) && col_reg != '0);
    assign last     = ocol_end && ((orow_reg + ROW_BITS'(1)) == h_row);
    assign col      = col_reg;

    always_comb
    begin
        ctl.emit     = emit;
        ctl.top_ok   = orow_reg != '0;
        ctl.bot_ok   = (orow_reg + ROW_BITS'(1)) != h_row;
        ctl.left_ok  = ocol_reg != '0;
        ctl.right_ok = !ocol_end;
        ctl.last     = last;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (proc)
        begin
            if (emit && last)
            begin
                col_next  = '0;
                row_next  = '0;
                ocol_next = '0;
                orow_next = '0;
            end
            else
            begin
                col_next = col_end ? '0 : col_reg + COL_BITS'(1);
                row_next = col_end ? row_reg + ROW_BITS'(1) : row_reg;
                if (emit)
                begin
                    ocol_next = ocol_end ? '0 : ocol_reg + COL_BITS'(1);
                    orow_next = ocol_end ? orow_reg + ROW_BITS'(1) : orow_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

endmodule

FILE: rtl/lap_line_buf.sv
`timescale 1ns / 1ps
// Two line memories that hold the upper and middle rows of the window.
// Depends on lap_pkg. Read data is registered; the upper row is written back
// from the delayed middle-row read and bypassed when a read hits that write.
module lap_line_buf #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_BITS  = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                wr_en,
    input  logic                s1_valid,
    input  logic [COL_BITS-1:0] col,
    input  lap_pkg::pixel_t     pix_in,
    output lap_pkg::pixel_t     up_out,
    output lap_pkg::pixel_t     mid_out
);
    import lap_pkg::*;

    pixel_t              upper_mem [MAX_WIDTH];
    pixel_t              middle_mem [MAX_WIDTH];
    pixel_t              up_rd_reg;
    pixel_t              mid_rd_reg;
    pixel_t              byp_reg;
    logic [COL_BITS-1:0] col_d_reg;
    logic                hit_reg;
    logic                up_we;

    assign up_we = adv && s1_valid;

    always_ff @(posedge clk)
    begin
        if (adv)
            mid_rd_reg <= middle_mem[col];
        if (wr_en)
            middle_mem[col] <= pix_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            up_rd_reg <= upper_mem[col];
        if (up_we)
            upper_mem[col_d_reg] <= mid_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp_reg   <= mid_rd_reg;
            col_d_reg <= col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (adv)
            hit_reg <= up_we && (col_d_reg == col);
    end

    assign up_out  = hit_reg ? byp_reg : up_rd_reg;
    assign mid_out = mid_rd_reg;

endmodule

FILE: rtl/lap_filter.sv
`timescale 1ns / 1ps
// 3x3 tap window and the Laplacian kernel with edge masking and clamping.
// Depends on lap_pkg.
module lap_filter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  lap_pkg::pixel_t   up_in,
    input  lap_pkg::pixel_t   mid_in,
    input  lap_pkg::pixel_t   cur_in,
    input  lap_pkg::lap_ctl_t ctl,
    output lap_pkg::pixel_t   pix_out
);
    import lap_pkg::*;

    localparam int SUM_W = CH_W + 4;

    pixel_t tap_reg [3][3];
    logic   row_ok [3];
    logic   col_ok [3];

    function automatic logic [CH_W-1:0] kernel(input logic [CH_W-1:0] p [3][3],
                                               input logic r_ok [3],
                                               input logic c_ok [3]);
        logic signed [SUM_W-1:0] sum;
        sum = signed'({1'b0, p[1][1], 3'b000});
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1) && r_ok[i] && c_ok[j])
                    sum = sum - signed'(SUM_W'(p[i][j]));
            end
        end
        if (sum < 0)
            return '0;
        else if (sum > signed'(SUM_W'(255)))
            return '1;
        else
            return sum[CH_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    tap_reg[i][j] <= '0;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tap_reg[i][0] <= tap_reg[i][1];
                tap_reg[i][1] <= tap_reg[i][2];
            end
            tap_reg[0][2] <= up_in;
            tap_reg[1][2] <= mid_in;
            tap_reg[2][2] <= cur_in;
        end
    end

    always_comb
    begin
        row_ok[0] = ctl.top_ok;
        row_ok[1] = 1'b1;
        row_ok[2] = ctl.bot_ok;
        col_ok[0] = ctl.left_ok;
        col_ok[1] = 1'b1;
        col_ok[2] = ctl.right_ok;
    end

    always_comb
    begin
        logic [CH_W-1:0] r_p [3][3];
        logic [CH_W-1:0] g_p [3][3];
        logic [CH_W-1:0] b_p [3][3];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r_p[i][j] = tap_reg[i][j].red;
                g_p[i][j] = tap_reg[i][j].green;
                b_p[i][j] = tap_reg[i][j].blue;
            end
        end
        pix_out.red   = kernel(r_p, row_ok, col_ok);
        pix_out.green = kernel(g_p, row_ok, col_ok);
        pix_out.blue  = kernel(b_p, row_ok, col_ok);
    end

endmodule

FILE: rtl/rgb_laplacian_3x3_convolution_core.sv
`timescale 1ns / 1ps
// RGB 3x3 Laplacian edge filter core, top level.
// Depends on lap_pkg, lap_ctrl, lap_line_buf and lap_filter.
//
// Pixels enter in raster order on the s_axis channel with tuser low. Each
// request with tuser high drains one pending output once the frame's pixels
// are in; drain requests sent earlier are taken and dropped. A frame needs
// width * height pixel requests followed by width + 1 drain requests.
// Filtered pixels leave on m_axis; tlast marks the final pixel of a frame,
// after which the core starts the next frame.
// The core takes one request per clock while m_axis is not stalled. The
// output for a pixel is produced by the request that arrives one row plus
// one pixel later and reaches m_axis through the line memory read
// registers, the tap window and the output register, loaded in that order.
// When the receiver stalls, the output register holds and the whole pipeline
// halts, so s_axis_tready drops while a result waits and tready is low.
// The cfg channel writes image width (index 0) and height (index 1); each
// write restarts the frame. It is always ready and must only be used while
// the core is idle. Reset loads width 640 and height 480, empties the
// pipeline and restarts the frame; line memory contents are not cleared.
module rgb_laplacian_3x3_convolution_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lap_pkg::PIX_W-1:0]     s_axis_tdata,  // in_red, in_green, in_blue
    input  logic                          s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lap_pkg::PIX_W-1:0]     m_axis_tdata,  // out_red, out_green, out_blue
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lap_pkg::DIM_W-1:0]     cfg_data
);
    import lap_pkg::*;

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                adv;
    logic                in_fire;
    logic                proc;
    logic                draining;
    logic [COL_BITS-1:0] col;
    lap_ctl_t            ctl;
    pixel_t              pix_in;
    pixel_t              up_pix;
    pixel_t              mid_pix;
    pixel_t              filt_pix;

    logic                s1_valid_reg;
    pixel_t              s1_pix_reg;
    lap_ctl_t            s1_ctl_reg;
    logic                s2_valid_reg;
    lap_ctl_t            s2_ctl_reg;
    logic                out_valid_reg;
    pixel_t              out_pix_reg;
    logic                out_last_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;
    assign pix_in        = draining ? '0 : pixel_t'(s_axis_tdata);

    lap_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_BITS   (COL_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .req_type  (s_axis_tuser),
        .proc      (proc),
        .draining  (draining),
        .col       (col),
        .ctl       (ctl)
    );

    lap_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_BITS  (COL_BITS)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .wr_en    (proc),
        .s1_valid (s1_valid_reg),
        .col      (col),
        .pix_in   (pix_in),
        .up_out   (up_pix),
        .mid_out  (mid_pix)
    );

    lap_filter u_filter (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (adv && s1_valid_reg),
        .up_in    (up_pix),
        .mid_in   (mid_pix),
        .cur_in   (s1_pix_reg),
        .ctl      (s2_ctl_reg),
        .pix_out  (filt_pix)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= pix_in;
            out_pix_reg <= filt_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_ctl_reg    <= '0;
            s2_valid_reg  <= 1'b0;
            s2_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= proc;
            s1_ctl_reg   <= ctl;
            if (s1_valid_reg)
                s2_ctl_reg <= s1_ctl_reg;
            s2_valid_reg  <= s1_valid_reg && s1_ctl_reg.emit;
            out_valid_reg <= s2_valid_reg;
            out_last_reg  <= s2_ctl_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/lap_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the RGB Laplacian filter core and their binding.
// Depends on lap_pkg and rgb_laplacian_3x3_convolution_core.
module lap_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [lap_pkg::PIX_W-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);
    import lap_pkg::*;

    // An empty output register must never hold back a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    // A result taken this cycle frees room for a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while the output is being taken");

    // A waiting result stalls the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while a result is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed or was withdrawn");

endmodule

bind rgb_laplacian_3x3_convolution_core lap_checker u_lap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
